@@ rtl/core/xhs_pkg.sv @@
// Shared constants and types for the Xiph header splitter.
package xhs_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int TOTAL_BITS  = LENGTH_BITS + 2;

    typedef logic [LENGTH_BITS-1:0] t_len;
    typedef logic [TOTAL_BITS-1:0]  t_total;

    localparam t_len       CFG_RESET     = t_len'(30);
    localparam t_len       MIN_PREFIXED  = t_len'(6);
    localparam t_len       MIN_LACED     = t_len'(3);
    localparam t_len       PREFIX_OFFSET = t_len'(2);
    localparam logic [7:0] LACED_MARKER  = 8'h02;
    localparam logic [7:0] LACE_RUN      = 8'hff;
    localparam t_total     LACE_STEP     = t_total'(256);

    typedef struct packed {
        logic [7:0] data_byte;
        t_len       buffer_length;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic status;
        t_len first_length;
        t_len second_length;
        t_len third_length;
        t_len first_offset;
        t_len second_offset;
        t_len third_offset;
    } t_result;

endpackage

@@ rtl/core/xhs_in_if.sv @@
// Byte input channel of the header splitter.
interface xhs_in_if;
    logic                  valid;
    logic                  ready;
    logic [7:0]            data_byte;
    xhs_pkg::t_len         buffer_length;
    logic                  last_byte;

    modport source (output valid, output data_byte, output buffer_length, output last_byte,
                    input ready);
    modport sink (input valid, input data_byte, input buffer_length, input last_byte,
                  output ready);
endinterface

@@ rtl/core/xhs_out_if.sv @@
// Result output channel of the header splitter.
interface xhs_out_if;
    logic          valid;
    logic          ready;
    logic          status;
    xhs_pkg::t_len first_length;
    xhs_pkg::t_len second_length;
    xhs_pkg::t_len third_length;
    xhs_pkg::t_len first_offset;
    xhs_pkg::t_len second_offset;
    xhs_pkg::t_len third_offset;

    modport source (output valid, output status, output first_length, output second_length,
                    output third_length, output first_offset, output second_offset,
                    output third_offset, input ready);
    modport sink (input valid, input status, input first_length, input second_length,
                  input third_length, input first_offset, input second_offset,
                  input third_offset, output ready);
endinterface

@@ rtl/core/xhs_cfg_if.sv @@
// Configuration write channel of the header splitter.
interface xhs_cfg_if;
    logic          valid;
    logic          ready;
    xhs_pkg::t_len data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/xhs_parser.sv @@
// Per-byte layout parser that holds the split state and forms the result.
module xhs_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  xhs_pkg::t_item   i_item,
    input  xhs_pkg::t_len    i_expected_first_size,
    output xhs_pkg::t_result o_result
);

    typedef enum logic [1:0] {
        UNDECIDED,
        PREFIXED,
        LACED,
        FINISHED
    } t_mode;

    t_mode                r_mode;
    t_mode                n_mode;
    xhs_pkg::t_len        r_pos;
    xhs_pkg::t_len        n_pos;
    logic [1:0]           r_hidx;
    logic [1:0]           n_hidx;
    xhs_pkg::t_total      r_total;
    xhs_pkg::t_total      n_total;
    xhs_pkg::t_len        r_skip;
    xhs_pkg::t_len        n_skip;
    logic [7:0]           r_high;
    logic [7:0]           n_high;
    xhs_pkg::t_len        r_len [3];
    xhs_pkg::t_len        n_len [3];
    xhs_pkg::t_len        r_off [3];
    xhs_pkg::t_len        n_off [3];
    logic                 r_err;
    logic                 n_err;
    logic                 r_low;
    logic                 n_low;

    logic [7:0]           b;
    xhs_pkg::t_len        size;
    xhs_pkg::t_total      size_ext;
    xhs_pkg::t_len        word;
    logic                 lace_go;
    xhs_pkg::t_total      lt;
    logic                 lh;
    xhs_pkg::t_len        llen0;
    xhs_pkg::t_len        lcur;
    xhs_pkg::t_total      lsum;
    xhs_pkg::t_total      psum;
    xhs_pkg::t_len        pos_next;
    logic                 ok;

    assign b        = i_item.data_byte;
    assign size     = i_item.buffer_length;
    assign size_ext = xhs_pkg::t_total'(size);
    assign word     = {r_high, b};
    assign pos_next = r_pos + xhs_pkg::t_len'(1);

    always_comb begin
        n_mode  = r_mode;
        n_pos   = (r_pos == '1) ? r_pos : pos_next;
        n_hidx  = r_hidx;
        n_total = r_total;
        n_skip  = r_skip;
        n_high  = r_high;
        n_len   = r_len;
        n_off   = r_off;
        n_err   = r_err;
        n_low   = r_low;
        lace_go = 1'b0;
        lt      = r_total;
        lh      = r_hidx[0];
        llen0   = r_len[0];
        lcur    = '0;
        lsum    = '0;
        psum    = r_total + xhs_pkg::t_total'(word);

        unique case (r_mode)
            UNDECIDED: begin
                if (r_pos == '0) begin
                    n_high = b;
                end else if (size >= xhs_pkg::MIN_PREFIXED && word == i_expected_first_size) begin
                    n_mode   = PREFIXED;
                    n_len[0] = word;
                    n_off[0] = xhs_pkg::PREFIX_OFFSET;
                    n_total  = xhs_pkg::t_total'(xhs_pkg::MIN_PREFIXED)
                               + xhs_pkg::t_total'(word);
                    if (n_total > size_ext) begin
                        n_err  = 1'b1;
                        n_mode = FINISHED;
                    end else begin
                        n_skip = word;
                        n_hidx = 2'd1;
                        n_low  = 1'b0;
                    end
                end else if (size >= xhs_pkg::MIN_LACED && r_high == xhs_pkg::LACED_MARKER) begin
                    n_mode  = LACED;
                    n_hidx  = 2'd0;
                    lace_go = 1'b1;
                    lt      = xhs_pkg::t_total'(xhs_pkg::MIN_LACED);
                    lh      = 1'b0;
                    llen0   = '0;
                end else begin
                    n_err  = 1'b1;
                    n_mode = FINISHED;
                end
            end
            PREFIXED: begin
                if (r_skip != '0) begin
                    n_skip = r_skip - xhs_pkg::t_len'(1);
                end else if (!r_low) begin
                    n_high = b;
                    n_low  = 1'b1;
                end else begin
                    n_low = 1'b0;
                    case (r_hidx)
                        2'd0: begin
                            n_len[0] = word;
                            n_off[0] = pos_next;
                        end
                        2'd1: begin
                            n_len[1] = word;
                            n_off[1] = pos_next;
                        end
                        2'd2: begin
                            n_len[2] = word;
                            n_off[2] = pos_next;
                        end
                        default: begin
                            n_err  = 1'b1;
                            n_mode = FINISHED;
                        end
                    endcase
                    if (r_hidx != 2'd3) begin
                        if (psum > size_ext) begin
                            n_err  = 1'b1;
                            n_mode = FINISHED;
                        end else begin
                            n_total = psum;
                            n_skip  = word;
                            n_hidx  = r_hidx + 2'd1;
                            if (r_hidx == 2'd2) begin
                                n_mode = FINISHED;
                            end
                        end
                    end
                end
            end
            LACED: begin
                lace_go = 1'b1;
            end
            FINISHED: begin
            end
        endcase

        if (lace_go) begin
            lcur = lh ? r_len[1] : llen0;
            if (lt < size_ext && b == xhs_pkg::LACE_RUN) begin
                lcur    = lcur + xhs_pkg::t_len'(xhs_pkg::LACE_RUN);
                n_total = lt + xhs_pkg::LACE_STEP;
                if (lh) begin
                    n_len[1] = lcur;
                end else begin
                    n_len[0] = lcur;
                end
            end else begin
                lcur    = lcur + xhs_pkg::t_len'(b);
                lsum    = lt + xhs_pkg::t_total'(b);
                n_total = lsum;
                if (lh) begin
                    n_len[1] = lcur;
                end else begin
                    n_len[0] = lcur;
                end
                if (lsum > size_ext) begin
                    n_err  = 1'b1;
                    n_mode = FINISHED;
                end else if (!lh) begin
                    n_hidx   = 2'd1;
                    n_len[1] = '0;
                end else begin
                    n_len[2] = size - lsum[xhs_pkg::LENGTH_BITS-1:0];
                    n_off[0] = pos_next;
                    n_off[1] = pos_next + llen0;
                    n_off[2] = pos_next + llen0 + lcur;
                    n_mode   = FINISHED;
                end
            end
        end
    end

    assign ok = (n_mode == FINISHED) && !n_err;

    always_comb begin
        o_result.status        = !ok;
        o_result.first_length  = ok ? n_len[0] : '0;
        o_result.second_length = ok ? n_len[1] : '0;
        o_result.third_length  = ok ? n_len[2] : '0;
        o_result.first_offset  = ok ? n_off[0] : '0;
        o_result.second_offset = ok ? n_off[1] : '0;
        o_result.third_offset  = ok ? n_off[2] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_item.last_byte)) begin
            r_mode  <= UNDECIDED;
            r_pos   <= '0;
            r_hidx  <= '0;
            r_total <= '0;
            r_skip  <= '0;
            r_high  <= '0;
            r_len   <= '{default: '0};
            r_off   <= '{default: '0};
            r_err   <= 1'b0;
            r_low   <= 1'b0;
        end else if (i_go) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_hidx  <= n_hidx;
            r_total <= n_total;
            r_skip  <= n_skip;
            r_high  <= n_high;
            r_len   <= n_len;
            r_off   <= n_off;
            r_err   <= n_err;
            r_low   <= n_low;
        end
    end

endmodule

@@ rtl/core/xiph_header_splitter_unit.sv @@
// Top level of the Xiph header splitter: input register, parser and result register.
// A result transaction is written to the result register when the last byte leaves the
// input register through the parser, and the result register presents it.
// Throughput: one byte per cycle; the input register and the result register decouple
// the two channels, so a waiting result stalls input only on a further last byte.
// Reset clears the parser state and both valid flags and sets the first-size register to 30.
module xiph_header_splitter_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    xhs_in_if.sink    i_byte,
    xhs_cfg_if.sink   i_cfg,
    xhs_out_if.source o_result
);

    logic             r_in_valid;
    xhs_pkg::t_item   r_in;
    logic             r_out_valid;
    xhs_pkg::t_result r_out;
    xhs_pkg::t_len    r_cfg;
    xhs_pkg::t_result res;
    logic             go;

    assign go           = r_in_valid && (!r_in.last_byte || !r_out_valid || o_result.ready);
    assign i_byte.ready = !r_in_valid || go;
    assign i_cfg.ready  = 1'b1;

    xhs_parser u_parser (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_go                  (go),
        .i_item                (r_in),
        .i_expected_first_size (r_cfg),
        .o_result              (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg       <= xhs_pkg::CFG_RESET;
        end else begin
            if (i_byte.valid && i_byte.ready) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end
            if (go && r_in.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_cfg <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in.data_byte     <= i_byte.data_byte;
            r_in.buffer_length <= i_byte.buffer_length;
            r_in.last_byte     <= i_byte.last_byte;
        end
        if (go && r_in.last_byte) begin
            r_out <= res;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.status        = r_out.status;
    assign o_result.first_length  = r_out.first_length;
    assign o_result.second_length = r_out.second_length;
    assign o_result.third_length  = r_out.third_length;
    assign o_result.first_offset  = r_out.first_offset;
    assign o_result.second_offset = r_out.second_offset;
    assign o_result.third_offset  = r_out.third_offset;

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status) |->
            (r_out.first_length == '0 && r_out.second_length == '0 &&
             r_out.third_length == '0 && r_out.first_offset == '0 &&
             r_out.second_offset == '0 && r_out.third_offset == '0))
        else $error("Corrupt result carries nonzero fields.");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in.last_byte))
        else $error("Result appeared without a last byte.");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !(go && r_in.last_byte))
        else $error("Pending result overwritten.");

endmodule

@@ verif/xiph_header_splitter_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the Xiph header splitter, with directed and random setup buffers.
module xiph_header_splitter_unit_tb;

    localparam int MAX_GAP      = 13;
    localparam int LONG_HOLD    = 300;
    localparam int CFG_SETTLE   = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int MAX_FULL     = 600;
    localparam int LEN_TOP      = 65535;
    localparam int LONG_FIRST   = 60;
    localparam int LONG_SECOND  = 29;

    typedef logic [7:0] t_bytes[$];
    typedef enum int {PH_UNDECIDED, PH_PREFIXED, PH_LACED, PH_DONE} t_phase;
    typedef enum int {KIND_PREFIXED, KIND_LACED, KIND_NOISE} t_kind;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    xhs_in_if  in_ch();
    xhs_cfg_if cfg_ch();
    xhs_out_if res_ch();

    xiph_header_splitter_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (in_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    xhs_pkg::t_len first_size;
    t_phase        split_phase;
    int unsigned   split_pos;
    int unsigned   split_hdr;
    int unsigned   split_total;
    int unsigned   split_skip;
    int unsigned   split_hi;
    int unsigned   split_len[3];
    int unsigned   split_off[3];
    bit            split_err;
    bit            split_have_high;

    xhs_pkg::t_result expected_splits[$];
    xhs_pkg::t_result got_split;
    xhs_pkg::t_result want_split;

    bit     tx_idle = 1'b1;
    bit     rx_idle = 1'b1;
    int     hold_requested = 0;
    int     hold_served = 0;
    int     hold_left = 0;
    int     rx_wait = 0;
    int     errors = 0;
    int     cycle_count = 0;
    longint bytes_sent = 0;

    function automatic void split_clear();
        split_phase     = PH_UNDECIDED;
        split_pos       = 0;
        split_hdr       = 0;
        split_total     = 0;
        split_skip      = 0;
        split_hi        = 0;
        split_err       = 1'b0;
        split_have_high = 1'b0;
        for (int k = 0; k < 3; k++) begin
            split_len[k] = 0;
            split_off[k] = 0;
        end
    endfunction

    function automatic void split_fail();
        split_err   = 1'b1;
        split_phase = PH_DONE;
    endfunction

    function automatic void lace_length(input int unsigned b, input int unsigned pos,
                                        input int unsigned size);
        int unsigned h;
        h = split_hdr & 1;
        if (split_total < size && b == xhs_pkg::LACE_RUN) begin
            split_len[h] += xhs_pkg::LACE_RUN;
            split_total  += xhs_pkg::LACE_STEP;
            return;
        end
        split_len[h] += b;
        split_total  += b;
        if (split_total > size) begin
            split_fail();
        end else if (h == 0) begin
            split_hdr    = 1;
            split_len[1] = 0;
        end else begin
            split_len[2] = (size - split_total) & LEN_TOP;
            split_off[0] = (pos + 1) & LEN_TOP;
            split_off[1] = (split_off[0] + split_len[0]) & LEN_TOP;
            split_off[2] = (split_off[1] + split_len[1]) & LEN_TOP;
            split_phase  = PH_DONE;
        end
    endfunction

    function automatic void prefix_length(input int unsigned b, input int unsigned pos,
                                          input int unsigned size);
        int unsigned w;
        int unsigned h;
        if (split_skip > 0) begin
            split_skip--;
            return;
        end
        if (!split_have_high) begin
            split_hi        = b;
            split_have_high = 1'b1;
            return;
        end
        split_have_high = 1'b0;
        w = (split_hi << 8) | b;
        h = split_hdr;
        split_len[h] = w;
        split_off[h] = (pos + 1) & LEN_TOP;
        if (split_total + w > size) begin
            split_fail();
            return;
        end
        split_total += w;
        split_skip   = w;
        split_hdr    = h + 1;
        if (split_hdr == 3) split_phase = PH_DONE;
    endfunction

    function automatic bit split_byte(input xhs_pkg::t_item it, output xhs_pkg::t_result res);
        int unsigned b;
        int unsigned size;
        int unsigned pos;
        int unsigned word;
        b    = it.data_byte;
        size = it.buffer_length;
        pos  = split_pos;
        res  = '0;
        case (split_phase)
            PH_UNDECIDED: begin
                if (pos == 0) begin
                    split_hi = b;
                end else begin
                    word = (split_hi << 8) | b;
                    if (size >= xhs_pkg::MIN_PREFIXED && word == first_size) begin
                        split_phase  = PH_PREFIXED;
                        split_len[0] = word;
                        split_off[0] = xhs_pkg::PREFIX_OFFSET;
                        split_total  = xhs_pkg::MIN_PREFIXED + word;
                        if (split_total > size) begin
                            split_fail();
                        end else begin
                            split_skip      = word;
                            split_hdr       = 1;
                            split_have_high = 1'b0;
                        end
                    end else if (size >= xhs_pkg::MIN_LACED &&
                                 split_hi == xhs_pkg::LACED_MARKER) begin
                        split_phase  = PH_LACED;
                        split_hdr    = 0;
                        split_total  = xhs_pkg::MIN_LACED;
                        split_len[0] = 0;
                        lace_length(b, pos, size);
                    end else begin
                        split_fail();
                    end
                end
            end
            PH_PREFIXED: prefix_length(b, pos, size);
            PH_LACED:    lace_length(b, pos, size);
            default: ;
        endcase
        if (split_pos < LEN_TOP) split_pos++;
        if (!it.last_byte) return 1'b0;
        if (split_phase == PH_DONE && !split_err) begin
            res.status        = 1'b0;
            res.first_length  = xhs_pkg::t_len'(split_len[0]);
            res.second_length = xhs_pkg::t_len'(split_len[1]);
            res.third_length  = xhs_pkg::t_len'(split_len[2]);
            res.first_offset  = xhs_pkg::t_len'(split_off[0]);
            res.second_offset = xhs_pkg::t_len'(split_off[1]);
            res.third_offset  = xhs_pkg::t_len'(split_off[2]);
        end else begin
            res.status = 1'b1;
        end
        split_clear();
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic int unsigned pick_length();
        if ($urandom_range(0, 15) == 0) return 255;
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 300);
        return $urandom_range(0, 12);
    endfunction

    always @(posedge i_clk) begin
        if (hold_served != hold_requested) begin
            hold_left   = LONG_HOLD;
            hold_served = hold_requested;
        end
        if (res_ch.valid && res_ch.ready) begin
            rx_wait = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got_split = '{res_ch.status, res_ch.first_length, res_ch.second_length,
                          res_ch.third_length, res_ch.first_offset, res_ch.second_offset,
                          res_ch.third_offset};
            if (expected_splits.size() == 0) begin
                $display("%0t: result transaction with none expected, expected nothing, actual %h",
                         $time, got_split);
                errors++;
            end else begin
                want_split = expected_splits.pop_front();
                check_field("status", want_split.status, got_split.status);
                check_field("first_length", want_split.first_length, got_split.first_length);
                check_field("second_length", want_split.second_length, got_split.second_length);
                check_field("third_length", want_split.third_length, got_split.third_length);
                check_field("first_offset", want_split.first_offset, got_split.first_offset);
                check_field("second_offset", want_split.second_offset, got_split.second_offset);
                check_field("third_offset", want_split.third_offset, got_split.third_offset);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("xiph_header_splitter_unit_tb: done, errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] d, input xhs_pkg::t_len len, input logic last);
        int               gap;
        xhs_pkg::t_item   it;
        xhs_pkg::t_result res;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= d;
        in_ch.buffer_length <= len;
        in_ch.last_byte     <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        it = '{data_byte: d, buffer_length: len, last_byte: last};
        if (split_byte(it, res)) expected_splits.push_back(res);
        bytes_sent++;
    endtask

    task automatic send_buffer(input t_bytes q, input xhs_pkg::t_len len, input bit jitter);
        xhs_pkg::t_len l;
        for (int i = 0; i < q.size(); i++) begin
            l = len;
            if (jitter && $urandom_range(0, 7) == 0) l = xhs_pkg::t_len'($urandom);
            send_byte(q[i], l, i == q.size() - 1);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_splits.size() != 0);
    endtask

    task automatic write_first_size(input xhs_pkg::t_len v);
        wait_drained();
        repeat (CFG_SETTLE) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        first_size = v;
    endtask

    task automatic send_random_buffer();
        t_bytes      q;
        t_kind       kind;
        int unsigned roll;
        int unsigned w2;
        int unsigned w3;
        int unsigned l0;
        int unsigned l1;
        int unsigned cut;
        int          need;
        int          size;
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
        roll = $urandom_range(0, 99);
        kind = roll < 45 ? KIND_PREFIXED : roll < 80 ? KIND_LACED : KIND_NOISE;
        case (kind)
            KIND_PREFIXED: begin
                q.push_back(first_size[15:8]);
                q.push_back(first_size[7:0]);
                if (first_size > MAX_FULL) begin
                    repeat ($urandom_range(0, 4)) q.push_back(8'($urandom));
                    need = xhs_pkg::MIN_PREFIXED + first_size;
                end else begin
                    w2 = pick_length();
                    w3 = pick_length();
                    repeat (first_size) q.push_back(8'($urandom));
                    q.push_back(8'(w2 >> 8));
                    q.push_back(8'(w2));
                    repeat (w2) q.push_back(8'($urandom));
                    q.push_back(8'(w3 >> 8));
                    q.push_back(8'(w3));
                    repeat (w3) q.push_back(8'($urandom));
                    need = xhs_pkg::MIN_PREFIXED + first_size + w2 + w3;
                end
            end
            KIND_LACED: begin
                l0 = pick_length();
                l1 = pick_length();
                q.push_back(xhs_pkg::LACED_MARKER);
                repeat (l0 / 255) q.push_back(xhs_pkg::LACE_RUN);
                q.push_back(8'(l0 % 255));
                repeat (l1 / 255) q.push_back(xhs_pkg::LACE_RUN);
                q.push_back(8'(l1 % 255));
                need = xhs_pkg::MIN_LACED + xhs_pkg::LACE_STEP * (l0 / 255 + l1 / 255)
                       + l0 % 255 + l1 % 255;
            end
            default: begin
                repeat ($urandom_range(1, 8)) q.push_back(8'($urandom));
                if ($urandom_range(0, 2) == 0) q[0] = xhs_pkg::LACED_MARKER;
                need = $urandom_range(0, 12);
            end
        endcase
        repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
        roll = $urandom_range(0, 9);
        if (roll < 4) size = need;
        else if (roll < 7) size = need + $urandom_range(1, 10);
        else if (roll == 7) size = need + $urandom_range(0, LEN_TOP);
        else if (roll == 8) size = need - $urandom_range(1, 3);
        else size = $urandom_range(0, LEN_TOP);
        if (size < 0) size = 0;
        if (size > LEN_TOP) size = LEN_TOP;
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, q.size());
            while (q.size() > cut) void'(q.pop_back());
        end
        send_buffer(q, xhs_pkg::t_len'(size), $urandom_range(0, 19) == 0);
    endtask

    task automatic run_random(input int budget);
        longint start;
        start = bytes_sent;
        while (bytes_sent - start < budget) send_random_buffer();
    endtask

    task automatic test_directed_cases();
        t_bytes q;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        q = {8'h00};
        send_buffer(q, 16'd0, 1'b0);
        q = {8'h00, 8'h1e, 8'hff};
        send_buffer(q, 16'd10, 1'b0);
        q = {xhs_pkg::LACED_MARKER, xhs_pkg::LACE_RUN};
        send_buffer(q, 16'd3, 1'b0);
        q = {xhs_pkg::LACED_MARKER, 8'h01, 8'h01, 8'haa};
        send_buffer(q, 16'hffff, 1'b0);
        q = {xhs_pkg::LACED_MARKER, xhs_pkg::LACE_RUN, 8'h00, 8'h00};
        send_buffer(q, 16'd259, 1'b0);
        q = {8'h07, 8'h07};
        send_buffer(q, 16'hffff, 1'b0);
        q = {xhs_pkg::LACED_MARKER, 8'h50};
        send_buffer(q, 16'd40, 1'b0);
        q = {xhs_pkg::LACED_MARKER, 8'h01};
        send_buffer(q, 16'd2, 1'b0);
        q = {xhs_pkg::LACED_MARKER, 8'h01};
        send_buffer(q, 16'hffff, 1'b0);
    endtask

    task automatic test_random_traffic();
        run_random(250);
        wait_drained();
        run_random(250);
    endtask

    task automatic test_output_backpressure();
        t_bytes q;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_requested++;
        repeat (40) begin
            q = {8'($urandom)};
            if ($urandom_range(0, 1) == 0) q = {xhs_pkg::LACED_MARKER, 8'($urandom)};
            send_buffer(q, xhs_pkg::t_len'($urandom), 1'b0);
        end
        wait_drained();
    endtask

    task automatic test_config_sweep();
        xhs_pkg::t_len settings[6];
        settings = '{16'd0, 16'd1, 16'h0203, 16'd7, 16'hffff, xhs_pkg::CFG_RESET};
        foreach (settings[i]) begin
            write_first_size(settings[i]);
            run_random(120);
        end
    endtask

    task automatic test_long_buffer();
        t_bytes q;
        write_first_size(xhs_pkg::t_len'(LONG_FIRST));
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        q.push_back(8'(LONG_FIRST >> 8));
        q.push_back(8'(LONG_FIRST));
        repeat (LONG_FIRST) q.push_back(8'($urandom));
        q.push_back(8'(LONG_SECOND >> 8));
        q.push_back(8'(LONG_SECOND));
        repeat (LONG_SECOND) q.push_back(8'($urandom));
        q.push_back(8'h00);
        q.push_back(8'h00);
        repeat (4) q.push_back(8'($urandom));
        send_buffer(q, xhs_pkg::t_len'(LEN_TOP), 1'b0);
        write_first_size(xhs_pkg::CFG_RESET);
    endtask

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = 8'h00;
        in_ch.buffer_length = '0;
        in_ch.last_byte     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        res_ch.ready        = 1'b0;
        first_size          = xhs_pkg::CFG_RESET;
        split_clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();
        test_config_sweep();
        test_long_buffer();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("xiph_header_splitter_unit_tb: done, clean");
        end else begin
            $display("xiph_header_splitter_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
